/* design/efd_pkg.sv */
// ----------------------------------------------------------------------------
// efd_pkg: shared types and constants for the escaped frame decoder
// Holds the packet store geometry, field widths, register indexes, the
// controller state type and the command/status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package efd_pkg;

    // Packet store geometry
    localparam int STORE_DEPTH = 64;
    localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

    // Field widths
    localparam int BYTE_W = 8;
    localparam int LEN_W  = 7;
    localparam int CIDX_W = 2;

    // Configuration register indexes
    typedef enum logic [CIDX_W-1:0] {
        CFG_START_BYTE  = 2'd0,
        CFG_STOP_BYTE   = 2'd1,
        CFG_ESCAPE_BYTE = 2'd2,
        CFG_MAX_LEN     = 2'd3
    } cfg_index_t;

    // Controller states: three parse modes plus packet delivery
    typedef enum logic [1:0] {
        ST_WAIT  = 2'd0,
        ST_DATA  = 2'd1,
        ST_ESC   = 2'd2,
        ST_DRAIN = 2'd3
    } ctrl_state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic accept;      // input transaction taken this cycle
        logic store;       // write in_byte at fill count, advance fill count
        logic fill_clear;  // drop stored payload
        logic drain_load;  // latch packet length, reset read index
        logic issue;       // read next packet entry into the delivery stage
    } efd_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic is_start;    // in_byte matches start byte
        logic is_stop;     // in_byte matches stop byte
        logic is_escape;   // in_byte matches escape byte
        logic at_limit;    // fill count has reached the length limit
        logic slot_free;   // delivery stage can take a new entry
        logic issue_last;  // next issued entry closes the packet
    } efd_sts_t;

endpackage

`default_nettype wire

/* design/efd_ctrl.sv */
// ----------------------------------------------------------------------------
// efd_ctrl: frame parser and delivery controller
// Tracks the parse mode (wait, data, escaped) and the delivery phase, and
// issues store, clear and read commands to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module efd_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire efd_pkg::efd_sts_t sts,
    output efd_pkg::efd_cmd_t      cmd
);

    efd_pkg::ctrl_state_t state_reg;
    efd_pkg::ctrl_state_t state_next;
    logic                 accept;

    // Hold input off while a packet is read out of the store
    assign in_stall = (state_reg == efd_pkg::ST_DRAIN);
    assign accept   = in_valid && !in_stall;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= efd_pkg::ST_WAIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            efd_pkg::ST_WAIT:
            begin
                if (accept && sts.is_start)
                begin
                    state_next = efd_pkg::ST_DATA;
                end
            end
            efd_pkg::ST_DATA:
            begin
                if (accept)
                begin
                    if (sts.is_stop)
                    begin
                        state_next = efd_pkg::ST_DRAIN;
                    end
                    else if (sts.is_escape)
                    begin
                        state_next = efd_pkg::ST_ESC;
                    end
                    else if (sts.is_start)
                    begin
                        state_next = efd_pkg::ST_DATA;
                    end
                    else if (sts.at_limit)
                    begin
                        state_next = efd_pkg::ST_WAIT;
                    end
                end
            end
            efd_pkg::ST_ESC:
            begin
                if (accept)
                begin
                    state_next = sts.at_limit ? efd_pkg::ST_WAIT : efd_pkg::ST_DATA;
                end
            end
            efd_pkg::ST_DRAIN:
            begin
                if (sts.slot_free && sts.issue_last)
                begin
                    state_next = efd_pkg::ST_WAIT;
                end
            end
            default:
            begin
                state_next = efd_pkg::ST_WAIT;
            end
        endcase
    end

    // Command outputs
    always_comb
    begin
        cmd            = '0;
        cmd.accept     = accept;
        case (state_reg)
            efd_pkg::ST_WAIT:
            begin
                cmd.accept = accept;
            end
            efd_pkg::ST_DATA:
            begin
                if (accept)
                begin
                    if (sts.is_stop)
                    begin
                        cmd.drain_load = 1'b1;
                        cmd.fill_clear = 1'b1;
                    end
                    else if (sts.is_escape)
                    begin
                        cmd.accept = 1'b1;
                    end
                    else if (sts.is_start || sts.at_limit)
                    begin
                        cmd.fill_clear = 1'b1;
                    end
                    else
                    begin
                        cmd.store = 1'b1;
                    end
                end
            end
            efd_pkg::ST_ESC:
            begin
                if (accept)
                begin
                    cmd.fill_clear = sts.at_limit;
                    cmd.store      = !sts.at_limit;
                end
            end
            efd_pkg::ST_DRAIN:
            begin
                cmd.issue = sts.slot_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    // Checks
    a_drain_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == efd_pkg::ST_DRAIN) |-> !cmd.accept && !cmd.store)
        else $error("input taken during delivery");

    a_stop_enters_drain: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.drain_load |=> (state_reg == efd_pkg::ST_DRAIN))
        else $error("delivery not started after stop byte");

    a_store_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.store |-> !cmd.fill_clear && !cmd.issue)
        else $error("store issued with clear or read");

endmodule

`default_nettype wire

/* design/efd_datapath.sv */
// ----------------------------------------------------------------------------
// efd_datapath: configuration, packet store and delivery pipeline
// Holds the configuration registers, the fill count, the packet store
// memory and a two-register delivery path (store read stage, output stage).
// ----------------------------------------------------------------------------
`default_nettype none

module efd_datapath (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_we,
    input  wire logic [efd_pkg::CIDX_W-1:0]          cfg_index,
    input  wire logic [efd_pkg::BYTE_W-1:0]          cfg_data,
    input  wire logic [efd_pkg::BYTE_W-1:0]          in_byte,
    input  wire efd_pkg::efd_cmd_t                   cmd,
    output efd_pkg::efd_sts_t                        sts,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic [efd_pkg::BYTE_W-1:0]               out_byte,
    output logic [efd_pkg::LEN_W-1:0]                packet_len,
    output logic                                     empty_packet,
    output logic                                     last_of_packet
);

    // Configuration registers
    logic [efd_pkg::BYTE_W-1:0] start_byte_reg;
    logic [efd_pkg::BYTE_W-1:0] stop_byte_reg;
    logic [efd_pkg::BYTE_W-1:0] escape_byte_reg;
    logic [efd_pkg::LEN_W-1:0]  max_len_reg;

    // Frame state
    logic [efd_pkg::LEN_W-1:0]  fill_count_reg;
    logic [efd_pkg::LEN_W-1:0]  fill_count_next;
    logic [efd_pkg::LEN_W-1:0]  limit;

    // Delivery control
    logic [efd_pkg::LEN_W-1:0]  len_reg;
    logic [efd_pkg::ADDR_W-1:0] rd_idx_reg;
    logic [efd_pkg::LEN_W-1:0]  rd_idx_inc;

    // Store read stage
    logic [efd_pkg::BYTE_W-1:0] mem [efd_pkg::STORE_DEPTH];
    logic [efd_pkg::BYTE_W-1:0] rd_data_reg;
    logic                       s1_valid_reg;
    logic                       s1_last_reg;
    logic                       s1_empty_reg;
    logic [efd_pkg::LEN_W-1:0]  s1_len_reg;

    // Output stage
    logic                       out_valid_reg;
    logic [efd_pkg::BYTE_W-1:0] out_byte_reg;
    logic [efd_pkg::LEN_W-1:0]  out_len_reg;
    logic                       out_empty_reg;
    logic                       out_last_reg;
    logic                       out_load;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_byte_reg  <= efd_pkg::BYTE_W'(1);
            stop_byte_reg   <= efd_pkg::BYTE_W'(4);
            escape_byte_reg <= efd_pkg::BYTE_W'(27);
            max_len_reg     <= efd_pkg::LEN_W'(64);
        end
        else if (cfg_we)
        begin
            case (efd_pkg::cfg_index_t'(cfg_index))
                efd_pkg::CFG_START_BYTE:  start_byte_reg  <= cfg_data;
                efd_pkg::CFG_STOP_BYTE:   stop_byte_reg   <= cfg_data;
                efd_pkg::CFG_ESCAPE_BYTE: escape_byte_reg <= cfg_data;
                efd_pkg::CFG_MAX_LEN:     max_len_reg     <= cfg_data[efd_pkg::LEN_W-1:0];
                default:                  start_byte_reg  <= start_byte_reg;
            endcase
        end
    end

    // Saturate the length limit at the store depth
    assign limit = (max_len_reg > efd_pkg::LEN_W'(efd_pkg::STORE_DEPTH))
                   ? efd_pkg::LEN_W'(efd_pkg::STORE_DEPTH) : max_len_reg;

    // Compare the incoming byte and report delivery progress
    assign rd_idx_inc = efd_pkg::LEN_W'(rd_idx_reg) + efd_pkg::LEN_W'(1);
    assign out_load   = s1_valid_reg && (!out_valid_reg || !out_stall);

    always_comb
    begin
        sts            = '0;
        sts.is_start   = (in_byte == start_byte_reg);
        sts.is_stop    = (in_byte == stop_byte_reg);
        sts.is_escape  = (in_byte == escape_byte_reg);
        sts.at_limit   = (fill_count_reg >= limit);
        sts.slot_free  = !s1_valid_reg || out_load;
        sts.issue_last = (len_reg == '0) || (rd_idx_inc == len_reg);
    end

    // Advance or clear the fill count
    always_comb
    begin
        fill_count_next = fill_count_reg;
        if (cmd.fill_clear)
        begin
            fill_count_next = '0;
        end
        else if (cmd.store)
        begin
            fill_count_next = fill_count_reg + efd_pkg::LEN_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_count_reg <= '0;
        end
        else
        begin
            fill_count_reg <= fill_count_next;
        end
    end

    // Latch packet length and step the read index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg    <= '0;
            rd_idx_reg <= '0;
        end
        else if (cmd.drain_load)
        begin
            len_reg    <= fill_count_reg;
            rd_idx_reg <= '0;
        end
        else if (cmd.issue)
        begin
            rd_idx_reg <= rd_idx_reg + efd_pkg::ADDR_W'(1);
        end
    end

    // Packet store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.store)
        begin
            mem[fill_count_reg[efd_pkg::ADDR_W-1:0]] <= in_byte;
        end
        if (cmd.issue)
        begin
            rd_data_reg <= mem[rd_idx_reg];
        end
    end

    // Store read stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (cmd.issue)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (out_load)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    // Store read stage tags
    always_ff @(posedge clk)
    begin
        if (cmd.issue)
        begin
            s1_last_reg  <= sts.issue_last;
            s1_empty_reg <= (len_reg == '0);
            s1_len_reg   <= len_reg;
        end
    end

    // Output stage: load from the read stage, drop when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_byte_reg  <= s1_empty_reg ? '0 : rd_data_reg;
            out_len_reg   <= s1_len_reg;
            out_empty_reg <= s1_empty_reg;
            out_last_reg  <= s1_last_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign out_byte       = out_byte_reg;
    assign packet_len     = out_len_reg;
    assign empty_packet   = out_empty_reg;
    assign last_of_packet = out_last_reg;

    // Checks
    a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        fill_count_reg <= efd_pkg::LEN_W'(efd_pkg::STORE_DEPTH))
        else $error("fill count beyond store depth");

    a_store_below_limit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.store |-> (fill_count_reg < limit))
        else $error("store at or past length limit");

    a_issue_has_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.issue |-> (!s1_valid_reg || out_load))
        else $error("read issued into an occupied stage");

    a_issue_fills_stage: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.issue |=> s1_valid_reg)
        else $error("issued read lost");

endmodule

`default_nettype wire

/* design/escaped_frame_decoder.sv */
// ----------------------------------------------------------------------------
// escaped_frame_decoder: start/stop/escape framed packet decoder
// Recovers byte-stuffed packets from a received byte stream and delivers
// each completed packet as a run of bytes with a last marker.
// ----------------------------------------------------------------------------
// One received byte is taken per cycle while the block parses a frame. A
// stop byte that closes a packet holds in_stall high while the packet is
// read out of the store through its single read port, one entry per cycle
// when the output side does not stall; an empty packet gives one marker
// result. Results pass through a store read register and an output
// register, and input resumes while the last results are still waiting on
// the output.
`default_nettype none

module escaped_frame_decoder (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_we,
    input  wire logic [efd_pkg::CIDX_W-1:0] cfg_index,
    input  wire logic [efd_pkg::BYTE_W-1:0] cfg_data,
    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire logic [efd_pkg::BYTE_W-1:0] in_byte,
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output logic [efd_pkg::BYTE_W-1:0]      out_byte,
    output logic [efd_pkg::LEN_W-1:0]       packet_len,
    output logic                            empty_packet,
    output logic                            last_of_packet
);

    efd_pkg::efd_cmd_t cmd;
    efd_pkg::efd_sts_t sts;

    // Parser and delivery control
    efd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Configuration, packet store and output path
    efd_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_byte        (in_byte),
        .cmd            (cmd),
        .sts            (sts),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_byte       (out_byte),
        .packet_len     (packet_len),
        .empty_packet   (empty_packet),
        .last_of_packet (last_of_packet)
    );

endmodule

`default_nettype wire

/* tb/sv/tb_escaped_frame_decoder.sv */
// ----------------------------------------------------------------------------
// tb_escaped_frame_decoder: self-checking bench for the escaped frame decoder
// Feeds framed byte streams (directed corner frames, then random frames with
// escapes, restarts, overflows and line noise) under several framing settings
// and handshake pressure, decodes every taken byte in a local frame parser
// and compares each delivered packet byte field by field.
// ----------------------------------------------------------------------------
module tb_escaped_frame_decoder;

    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE_CYCLES = 12;

    // One delivered packet byte as the parser predicts it
    typedef struct {
        logic [efd_pkg::BYTE_W-1:0] data;
        logic [efd_pkg::LEN_W-1:0]  len;
        logic                       empty;
        logic                       last;
    } packet_beat_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       cfg_we = 1'b0;
    efd_pkg::cfg_index_t        cfg_index = efd_pkg::CFG_START_BYTE;
    logic [efd_pkg::BYTE_W-1:0] cfg_data = '0;
    logic                       in_valid = 1'b0;
    logic                       in_stall;
    logic [efd_pkg::BYTE_W-1:0] in_byte = '0;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic [efd_pkg::BYTE_W-1:0] out_byte;
    logic [efd_pkg::LEN_W-1:0]  packet_len;
    logic                       empty_packet;
    logic                       last_of_packet;

    // Stimulus stream and expected deliveries
    logic [efd_pkg::BYTE_W-1:0] line_bytes[$];
    packet_beat_t               due_beats[$];
    logic                       byte_taken = 1'b0;
    int                         gap_pct = 0;
    int                         hold_pct = 0;

    // Frame parser state and its copy of the framing registers
    logic [efd_pkg::BYTE_W-1:0] frame_start = 8'd1;
    logic [efd_pkg::BYTE_W-1:0] frame_stop = 8'd4;
    logic [efd_pkg::BYTE_W-1:0] frame_escape = 8'd27;
    logic [efd_pkg::LEN_W-1:0]  len_max = 7'd64;
    efd_pkg::ctrl_state_t       parse_mode = efd_pkg::ST_WAIT;
    int                         fill = 0;
    logic [efd_pkg::BYTE_W-1:0] payload[efd_pkg::STORE_DEPTH];

    int cycle_count = 0;
    int bytes_queued = 0;
    int bytes_taken = 0;
    int beats_checked = 0;
    int packets_checked = 0;
    int settings_used = 1;
    int fail_count = 0;

    escaped_frame_decoder uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .in_byte        (in_byte),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_byte       (out_byte),
        .packet_len     (packet_len),
        .empty_packet   (empty_packet),
        .last_of_packet (last_of_packet)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    function automatic int length_limit();
        return (len_max > efd_pkg::STORE_DEPTH) ? efd_pkg::STORE_DEPTH : int'(len_max);
    endfunction

    // Store one payload byte, or drop the frame once the limit is reached
    task automatic keep_payload(input logic [efd_pkg::BYTE_W-1:0] b);
        if (fill >= length_limit() || fill >= efd_pkg::STORE_DEPTH)
        begin
            fill = 0;
            parse_mode = efd_pkg::ST_WAIT;
        end
        else
        begin
            payload[fill] = b;
            fill++;
            parse_mode = efd_pkg::ST_DATA;
        end
    endtask

    // Close the frame and queue its deliveries
    task automatic close_frame();
        packet_beat_t beat;
        if (fill == 0)
        begin
            beat = '{data: '0, len: '0, empty: 1'b1, last: 1'b1};
            due_beats.push_back(beat);
        end
        else
        begin
            for (int k = 0; k < fill; k++)
            begin
                beat = '{data: payload[k], len: efd_pkg::LEN_W'(fill), empty: 1'b0,
                         last: (k == fill - 1)};
                due_beats.push_back(beat);
            end
        end
        fill = 0;
        parse_mode = efd_pkg::ST_WAIT;
    endtask

    // Parse one received byte; stop, then escape, then start take priority
    task automatic parse_byte(input logic [efd_pkg::BYTE_W-1:0] b);
        case (parse_mode)
            efd_pkg::ST_DATA:
            begin
                if (b == frame_stop)
                    close_frame();
                else if (b == frame_escape)
                    parse_mode = efd_pkg::ST_ESC;
                else if (b == frame_start)
                begin
                    fill = 0;
                    parse_mode = efd_pkg::ST_DATA;
                end
                else
                    keep_payload(b);
            end
            efd_pkg::ST_ESC:
                keep_payload(b);
            default:
                parse_mode = (b == frame_start) ? efd_pkg::ST_DATA : efd_pkg::ST_WAIT;
        endcase
    endtask

    // Monitor: track register writes, parse taken bytes, check deliveries
    always @(posedge clk)
    begin
        packet_beat_t want;
        if (rst_n)
        begin
            cycle_count++;
            if (cfg_we)
            begin
                case (cfg_index)
                    efd_pkg::CFG_START_BYTE:  frame_start = cfg_data;
                    efd_pkg::CFG_STOP_BYTE:   frame_stop = cfg_data;
                    efd_pkg::CFG_ESCAPE_BYTE: frame_escape = cfg_data;
                    efd_pkg::CFG_MAX_LEN:     len_max = cfg_data[efd_pkg::LEN_W-1:0];
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
            begin
                bytes_taken++;
                parse_byte(in_byte);
            end
            if (out_valid && !out_stall)
            begin
                if (due_beats.size() == 0)
                begin
                    $error("unexpected delivery: out_byte %0h packet_len %0d", out_byte,
                           packet_len);
                    fail_count++;
                end
                else
                begin
                    want = due_beats.pop_front();
                    beats_checked++;
                    if (last_of_packet)
                        packets_checked++;
                    if (out_byte !== want.data)
                    begin
                        $error("out_byte: expected %0h, got %0h", want.data, out_byte);
                        fail_count++;
                    end
                    if (packet_len !== want.len)
                    begin
                        $error("packet_len: expected %0d, got %0d", want.len, packet_len);
                        fail_count++;
                    end
                    if (empty_packet !== want.empty)
                    begin
                        $error("empty_packet: expected %0b, got %0b", want.empty,
                               empty_packet);
                        fail_count++;
                    end
                    if (last_of_packet !== want.last)
                    begin
                        $error("last_of_packet: expected %0b, got %0b", want.last,
                               last_of_packet);
                        fail_count++;
                    end
                end
            end
        end
        byte_taken <= rst_n && in_valid && !in_stall;
    end

    // Driver: hold a stalled byte, otherwise send the next one or idle
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || byte_taken))
        begin
            if (line_bytes.size() > 0 && $urandom_range(99) >= gap_pct)
            begin
                in_valid <= 1'b1;
                in_byte <= line_bytes.pop_front();
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Receiver back-pressure
    always @(negedge clk)
    begin
        out_stall <= rst_n && ($urandom_range(99) < hold_pct);
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
            @(posedge clk);
        $display("Test completed with failures");
        $finish;
    end

    task automatic queue_byte(input logic [efd_pkg::BYTE_W-1:0] b);
        line_bytes.push_back(b);
        bytes_queued++;
    endtask

    task automatic write_reg(input efd_pkg::cfg_index_t idx,
                             input logic [efd_pkg::BYTE_W-1:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_framing(input logic [efd_pkg::BYTE_W-1:0] s,
                               input logic [efd_pkg::BYTE_W-1:0] p,
                               input logic [efd_pkg::BYTE_W-1:0] e,
                               input logic [efd_pkg::BYTE_W-1:0] m);
        write_reg(efd_pkg::CFG_START_BYTE, s);
        write_reg(efd_pkg::CFG_STOP_BYTE, p);
        write_reg(efd_pkg::CFG_ESCAPE_BYTE, e);
        write_reg(efd_pkg::CFG_MAX_LEN, m);
        settings_used++;
    endtask

    // Wait until every byte is taken and every delivery checked, then settle
    task automatic drain_all();
        while (bytes_taken != bytes_queued || due_beats.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Random frames: mostly well formed with escaped specials, some restarts,
    // missing stops, frames at the length limit and line noise between frames
    task automatic make_traffic(input int n);
        int made;
        int len;
        int lim;
        logic [efd_pkg::BYTE_W-1:0] b;
        made = 0;
        lim = length_limit();
        while (made < n)
        begin
            if ($urandom_range(99) < 8)
                queue_byte(efd_pkg::BYTE_W'($urandom_range(255)));
            else
            begin
                queue_byte(frame_start);
                made++;
                if ($urandom_range(9) == 0)
                    len = (lim > 0) ? lim - 1 + $urandom_range(2) : $urandom_range(1);
                else
                    len = $urandom_range(10);
                for (int k = 0; k < len; k++)
                begin
                    if ($urandom_range(24) == 0)
                        queue_byte(frame_start);
                    if ($urandom_range(3) == 0)
                    begin
                        case ($urandom_range(2))
                            0: b = frame_start;
                            1: b = frame_stop;
                            default: b = frame_escape;
                        endcase
                    end
                    else
                        b = efd_pkg::BYTE_W'($urandom_range(255));
                    if (b == frame_start || b == frame_stop || b == frame_escape)
                        queue_byte(frame_escape);
                    queue_byte(b);
                    made++;
                end
                if ($urandom_range(19) != 0)
                begin
                    queue_byte(frame_stop);
                    made++;
                end
            end
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset framing: noise, full escape set, restart into an empty packet
        gap_pct = 0;
        hold_pct = 0;
        queue_byte(8'h00);
        queue_byte(8'h04);
        queue_byte(8'h01);
        queue_byte(8'h00);
        queue_byte(8'hFF);
        queue_byte(8'h1B);
        queue_byte(8'h01);
        queue_byte(8'h1B);
        queue_byte(8'h04);
        queue_byte(8'h1B);
        queue_byte(8'h1B);
        queue_byte(8'h04);
        queue_byte(8'h01);
        queue_byte(8'h55);
        queue_byte(8'h01);
        queue_byte(8'h04);
        // Leave a frame open with three bytes stored
        queue_byte(8'h01);
        queue_byte(8'h11);
        queue_byte(8'h22);
        queue_byte(8'h33);
        drain_all();

        // Lower the limit mid-frame: next byte drops, then overflow while escaped
        write_reg(efd_pkg::CFG_MAX_LEN, 8'd2);
        settings_used++;
        gap_pct = 55;
        queue_byte(8'h33);
        queue_byte(8'h01);
        queue_byte(8'hB1);
        queue_byte(8'hB2);
        queue_byte(8'h1B);
        queue_byte(8'hC0);
        make_traffic(25);
        drain_all();

        // Extreme framing bytes, limit above the store size
        set_framing(8'h00, 8'hFF, 8'h80, 8'd100);
        gap_pct = 0;
        hold_pct = 55;
        make_traffic(30);
        drain_all();

        // Start and escape share a value, short limit
        set_framing(8'hAA, 8'h55, 8'hAA, 8'd5);
        gap_pct = 11;
        hold_pct = 11;
        make_traffic(25);
        drain_all();

        // Start equals stop, zero limit: only empty packets survive
        set_framing(8'h7E, 8'h7E, 8'h7D, 8'd0);
        make_traffic(15);
        drain_all();

        // Back to the reset framing with the full store
        set_framing(8'd1, 8'd4, 8'd27, 8'd64);
        gap_pct = 0;
        hold_pct = 0;
        make_traffic(30);
        drain_all();

        $display("Sent %0d bytes through %0d framing settings; checked %0d packet bytes",
                 bytes_taken, settings_used, beats_checked);
        $display("in %0d delivered packets under mixed send gaps and output stalls",
                 packets_checked);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
